// File: hw/rtl/pabs_pkg.sv
// Shared types and constants of the priority alarm beep sequencer.
`default_nettype none

package pabs_pkg;

  // Queue geometry
  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Request function codes
  typedef enum logic [1:0] {
    FN_TICK  = 2'd0,
    FN_TRIG  = 2'd1,
    FN_CLEAR = 2'd2,
    FN_STOP  = 2'd3
  } func_e;

  // Result status codes
  typedef enum logic [1:0] {
    STS_DONE = 2'd0,
    STS_DUP  = 2'd1,
    STS_FULL = 2'd2,
    STS_MISS = 2'd3
  } status_e;

  // Beep pattern phases
  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_ON    = 2'd1,
    PH_GAP   = 2'd2,
    PH_PAUSE = 2'd3
  } phase_e;

  // Top level control states
  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_EXEC   = 2'd1,
    S_REPORT = 2'd2
  } ctl_state_e;

  // Operation applied to every cell of the queue chain
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2
  } cell_op_e;

  // One queued alarm
  typedef struct packed {
    logic [7:0]  tag;
    logic [15:0] on_time;
    logic [15:0] gap_time;
    logic [7:0]  beeps;
    logic [15:0] pause_time;
    logic [15:0] limit;
    logic [7:0]  urg;
  } entry_t;

  // Broadcast control to the cell chain
  typedef struct packed {
    cell_op_e   op;
    logic [7:0] key;
    entry_t     ent;
  } cell_ctl_t;

  // Control into the pattern player
  typedef struct packed {
    logic step;
    logic first;
    logic restart;
  } play_ctl_t;

  // Result of one player step
  typedef struct packed {
    logic fin;
    logic level;
    logic drop;
  } play_res_t;

endpackage

`default_nettype wire

// File: hw/rtl/priority_alarm_beep_sequencer_core.sv
// Top level of the priority alarm beep sequencer: control, cell chain, player.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+----------------------------------------
//  in      | input     | in_valid_i / in_ready_o   | func_i, alarm_tag_i, pattern, urgency_i
//  out     | output    | out_valid_o / out_ready_i | buzzer_level_o, queue_busy_o,
//          |           |                          | tag_present_o, command_status_o,
//          |           |                          | entries_held_o
//
//  A command passes through capture, one chain update and report before its result.
//  A tick walks the player one pattern phase per cycle, at most 16 phases per tick.
//  Reset empties the queue and puts the pattern at the start of the first beep.
//  A result waits in the output register; the next item is taken once it is loaded.
`default_nettype none

module priority_alarm_beep_sequencer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  alarm_tag_i,
  input  logic [15:0] beep_on_time_i,
  input  logic [15:0] beep_gap_time_i,
  input  logic [7:0]  beeps_per_cycle_i,
  input  logic [15:0] cycle_pause_time_i,
  input  logic [15:0] cycle_limit_i,
  input  logic [7:0]  urgency_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        buzzer_level_o,
  output logic        queue_busy_o,
  output logic        tag_present_o,
  output logic [1:0]  command_status_o,
  output logic [3:0]  entries_held_o
);
  import pabs_pkg::*;

  ctl_state_e       state_q, state_d;
  func_e            req_func_q;
  logic [7:0]       req_tag_q;
  entry_t           req_ent_q;
  logic             first_q, first_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             level_q, level_d;
  status_e          status_q, status_d;

  logic             out_valid_q, out_valid_d;
  logic             out_level_q, out_busy_q, out_present_q;
  status_e          out_status_q;
  logic [3:0]       out_held_q;

  cell_ctl_t        cell_ctl;
  play_ctl_t        play_ctl;
  play_res_t        play_res;
  logic             shl_head;
  logic             load_out;
  logic             in_xfer;
  logic             any_hit;
  logic             is_full;
  logic             is_empty;

  entry_t           ent      [QUEUE_DEPTH];
  logic             gt       [QUEUE_DEPTH];
  logic             hit      [QUEUE_DEPTH];
  logic             shl      [QUEUE_DEPTH+1];
  logic [QUEUE_DEPTH-1:0] hit_vec;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign is_full    = (count_q == CNT_W'(QUEUE_DEPTH));
  assign is_empty   = (count_q == '0);
  assign any_hit    = |hit_vec;
  assign shl[0]     = shl_head;

  // Cell chain
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_ent, right_ent;
    logic   left_gt;

    assign left_ent   = (i == 0) ? ent[i] : ent[(i == 0) ? 0 : i-1];
    assign left_gt    = (i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i-1];
    assign right_ent  = (i == QUEUE_DEPTH-1) ? ent[i]
                      : ent[(i == QUEUE_DEPTH-1) ? i : i+1];
    assign hit_vec[i] = hit[i];

    pabs_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (cell_ctl),
      .occ_i       (CNT_W'(i) < count_q),
      .at_count_i  (CNT_W'(i) == count_q),
      .left_ent_i  (left_ent),
      .left_gt_i   (left_gt),
      .right_ent_i (right_ent),
      .shl_i       (shl[i]),
      .ent_o       (ent[i]),
      .gt_o        (gt[i]),
      .hit_o       (hit[i]),
      .shl_o       (shl[i+1])
    );
  end

  // Pattern player on the head cell
  pabs_player u_player (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (play_ctl),
    .empty_i (is_empty),
    .head_i  (ent[0]),
    .res_o   (play_res)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (req_func_q != FN_TICK || play_res.fin) begin
          state_d = S_REPORT;
        end
      end
      S_REPORT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    cell_ctl.op  = CELL_HOLD;
    cell_ctl.key = req_tag_q;
    cell_ctl.ent = req_ent_q;
    shl_head     = 1'b0;
    play_ctl     = '0;
    count_d      = count_q;
    level_d      = level_q;
    status_d     = status_q;
    first_d      = first_q;
    load_out     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        first_d = 1'b1;
      end
      S_EXEC: begin
        status_d = STS_DONE;
        level_d  = 1'b0;
        unique case (req_func_q)
          FN_TICK: begin
            play_ctl.step  = 1'b1;
            play_ctl.first = first_q;
            first_d        = 1'b0;
            level_d        = play_res.level;
            if (play_res.drop) begin
              cell_ctl.op = CELL_REMOVE;
              shl_head    = 1'b1;
              count_d     = count_q - CNT_W'(1);
            end
          end
          FN_TRIG: begin
            if (any_hit) begin
              status_d = STS_DUP;
            end else if (is_full) begin
              status_d = STS_FULL;
            end else begin
              cell_ctl.op      = CELL_INSERT;
              count_d          = count_q + CNT_W'(1);
              play_ctl.restart = gt[0] || is_empty;
            end
          end
          FN_CLEAR: begin
            if (!any_hit) begin
              status_d = STS_MISS;
            end else begin
              cell_ctl.op      = CELL_REMOVE;
              count_d          = count_q - CNT_W'(1);
              play_ctl.restart = hit[0];
            end
          end
          FN_STOP: begin
            count_d          = '0;
            play_ctl.restart = 1'b1;
          end
          default: status_d = STS_DONE;
        endcase
      end
      S_REPORT: begin
        load_out = !out_valid_q || out_ready_i;
      end
      default: first_d = 1'b1;
    endcase
  end

  assign out_valid_d = load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request capture and result payload
  always_ff @(posedge clk_i) begin
    level_q  <= level_d;
    status_q <= status_d;
    if (in_xfer) begin
      req_func_q           <= func_e'(func_i);
      req_tag_q            <= alarm_tag_i;
      req_ent_q.tag        <= alarm_tag_i;
      req_ent_q.on_time    <= beep_on_time_i;
      req_ent_q.gap_time   <= beep_gap_time_i;
      req_ent_q.beeps      <= beeps_per_cycle_i;
      req_ent_q.pause_time <= cycle_pause_time_i;
      req_ent_q.limit      <= cycle_limit_i;
      req_ent_q.urg        <= urgency_i;
    end
    if (load_out) begin
      out_level_q   <= level_q;
      out_busy_q    <= !is_empty;
      out_present_q <= any_hit;
      out_status_q  <= status_q;
      out_held_q    <= 4'(count_q);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign buzzer_level_o   = out_level_q;
  assign queue_busy_o     = out_busy_q;
  assign tag_present_o    = out_present_q;
  assign command_status_o = out_status_q;
  assign entries_held_o   = out_held_q;

endmodule

`default_nettype wire

// File: hw/rtl/pabs_cell.sv
// One queue cell: holds an alarm entry and shifts it to or from its neighbors.
`default_nettype none

module pabs_cell (
  input  logic               clk_i,
  input  pabs_pkg::cell_ctl_t ctl_i,
  input  logic               occ_i,
  input  logic               at_count_i,
  input  pabs_pkg::entry_t   left_ent_i,
  input  logic               left_gt_i,
  input  pabs_pkg::entry_t   right_ent_i,
  input  logic               shl_i,
  output pabs_pkg::entry_t   ent_o,
  output logic               gt_o,
  output logic               hit_o,
  output logic               shl_o
);
  import pabs_pkg::*;

  entry_t ent_q, ent_d;

  // Local compares against the broadcast key and urgency
  assign hit_o = occ_i && (ent_q.tag == ctl_i.key);
  assign gt_o  = occ_i && (ent_q.urg > ctl_i.ent.urg);
  assign shl_o = shl_i | hit_o;
  assign ent_o = ent_q;

  // Next content: take from a neighbor, take the new entry, or hold
  always_comb begin
    ent_d = ent_q;
    case (ctl_i.op)
      CELL_INSERT: begin
        if (left_gt_i) begin
          ent_d = left_ent_i;
        end else if (gt_o || at_count_i) begin
          ent_d = ctl_i.ent;
        end
      end
      CELL_REMOVE: begin
        if (shl_o) begin
          ent_d = right_ent_i;
        end
      end
      default: ent_d = ent_q;
    endcase
  end

  // Payload storage, no reset
  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

`default_nettype wire

// File: hw/rtl/pabs_player.sv
// Pattern player: steps the head alarm's beep pattern one phase per cycle while a step is requested.
`default_nettype none

module pabs_player (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pabs_pkg::play_ctl_t ctl_i,
  input  logic                empty_i,
  input  pabs_pkg::entry_t    head_i,
  output pabs_pkg::play_res_t res_o
);
  import pabs_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  beeps_q, beeps_d;
  logic [15:0] time_q, time_d;
  logic [15:0] cycles_q, cycles_d;
  logic        completed_q, completed_d;
  logic [3:0]  guard_q, guard_d;

  logic        completed;
  logic [3:0]  guard;
  logic [7:0]  nb;
  logic [15:0] nc;

  // One iteration of the tick loop
  always_comb begin
    phase_d     = phase_q;
    beeps_d     = beeps_q;
    time_d      = time_q;
    cycles_d    = cycles_q;
    completed_d = completed_q;
    guard_d     = guard_q;
    res_o       = '0;
    completed   = ctl_i.first ? 1'b0 : completed_q;
    guard       = ctl_i.first ? 4'd0 : guard_q;
    nb          = beeps_q;
    nc          = cycles_q;

    if (ctl_i.step) begin
      completed_d = completed;
      guard_d     = guard + 4'd1;
      if (empty_i) begin
        res_o.fin = 1'b1;
      end else if (phase_q != PH_START && time_q != 16'd0) begin
        time_d      = time_q - 16'd1;
        res_o.fin   = 1'b1;
        res_o.level = (phase_q == PH_ON);
      end else begin
        unique case (phase_q)
          PH_START: begin
            beeps_d = 8'd0;
            if (head_i.beeps != 8'd0) begin
              phase_d = PH_ON;
              time_d  = head_i.on_time;
            end else begin
              phase_d = PH_PAUSE;
              time_d  = head_i.pause_time;
            end
          end
          PH_ON: begin
            // both times zero: rest of the beeps take no time
            if (head_i.on_time == 16'd0 && head_i.gap_time == 16'd0) begin
              nb = head_i.beeps;
            end else if (beeps_q < head_i.beeps) begin
              nb = beeps_q + 8'd1;
            end
            beeps_d = nb;
            if (nb < head_i.beeps) begin
              phase_d = PH_GAP;
              time_d  = head_i.gap_time;
            end else begin
              phase_d = PH_PAUSE;
              time_d  = head_i.pause_time;
            end
          end
          PH_GAP: begin
            phase_d = PH_ON;
            time_d  = head_i.on_time;
          end
          PH_PAUSE: begin
            if (completed) begin
              // pattern already completed once in this tick: wait at the start
              phase_d   = PH_START;
              res_o.fin = 1'b1;
            end else begin
              completed_d = 1'b1;
              nc = (cycles_q != 16'hFFFF) ? cycles_q + 16'd1 : cycles_q;
              phase_d = PH_START;
              beeps_d = 8'd0;
              time_d  = 16'd0;
              if (head_i.limit != 16'd0 && nc >= head_i.limit) begin
                res_o.drop = 1'b1;
                cycles_d   = 16'd0;
              end else begin
                cycles_d = nc;
              end
            end
          end
          default: phase_d = PH_START;
        endcase
      end
      // loop bound of sixteen iterations
      if (!res_o.fin && !res_o.drop && guard == 4'd15) begin
        res_o.fin = 1'b1;
      end
    end

    // new head from a command
    if (ctl_i.restart) begin
      phase_d  = PH_START;
      beeps_d  = 8'd0;
      time_d   = 16'd0;
      cycles_d = 16'd0;
    end
  end

  // Pattern state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      beeps_q     <= 8'd0;
      time_q      <= 16'd0;
      cycles_q    <= 16'd0;
      completed_q <= 1'b0;
      guard_q     <= 4'd0;
    end else begin
      phase_q     <= phase_d;
      beeps_q     <= beeps_d;
      time_q      <= time_d;
      cycles_q    <= cycles_d;
      completed_q <= completed_d;
      guard_q     <= guard_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pabs_checker.sv
// Port level checks of the priority alarm beep sequencer, bound to the top level.
`default_nettype none

module pabs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       buzzer_level_o,
  input logic       queue_busy_o,
  input logic       tag_present_o,
  input logic [1:0] command_status_o,
  input logic [3:0] entries_held_o
);
  import pabs_pkg::*;

  // Busy flag tracks the entry count, which never exceeds the queue depth
  a_busy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((queue_busy_o == (entries_held_o != 4'd0)) &&
                     (entries_held_o <= 4'(QUEUE_DEPTH))))
    else $error("queue_busy or entries_held inconsistent");

  // Sounding only with a queued alarm, and never on a failed command
  a_sound_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && buzzer_level_o) |-> (queue_busy_o && command_status_o == STS_DONE))
    else $error("buzzer sounding without a queued alarm");

  // Missing tag cannot be present; a duplicate must be
  a_tag_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((command_status_o == STS_MISS) ? !tag_present_o :
                     ((command_status_o == STS_DUP) ? tag_present_o : 1'b1)))
    else $error("tag presence disagrees with command status");

  // A stalled result stays valid and unchanged until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable({buzzer_level_o, queue_busy_o, tag_present_o,
                               command_status_o, entries_held_o})))
    else $error("result dropped or changed while stalled");

  // One item in flight: ready drops right after an input transfer
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while an item is in flight");

endmodule

bind priority_alarm_beep_sequencer_core pabs_checker u_pabs_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .buzzer_level_o   (buzzer_level_o),
  .queue_busy_o     (queue_busy_o),
  .tag_present_o    (tag_present_o),
  .command_status_o (command_status_o),
  .entries_held_o   (entries_held_o)
);

`default_nettype wire

// File: test/priority_alarm_beep_sequencer_core_tb.sv
// Self-checking testbench of the priority alarm beep sequencer core.
`timescale 1ns / 1ps

module priority_alarm_beep_sequencer_core_tb;
  import pabs_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_ITEMS = 750;
  localparam int unsigned DRAIN_CYCLES = 24;

  // One request as seen on the input channel
  typedef struct packed {
    func_e       func;
    logic [7:0]  tag;
    logic [15:0] on_time;
    logic [15:0] gap_time;
    logic [7:0]  beeps;
    logic [15:0] pause_time;
    logic [15:0] limit;
    logic [7:0]  urg;
  } alarm_req_t;

  // One result as seen on the output channel
  typedef struct packed {
    logic       level;
    logic       busy;
    logic       present;
    status_e    status;
    logic [3:0] held;
  } alarm_rsp_t;

  // Scoreboard: shadow alarm queue plus beep pattern player
  class alarm_scoreboard;
    entry_t      slot [QUEUE_DEPTH];
    int unsigned held;
    logic [15:0] cycles_done;
    phase_e      phase;
    logic [7:0]  beeps_done;
    logic [15:0] time_left;
    alarm_rsp_t  alarm_rsp_q [$];
    int unsigned mismatches, checked;
    int unsigned n_tick, n_trig, n_clear, n_stop, n_sound, n_dup, n_full, n_miss;

    function new();
      for (int i = 0; i < QUEUE_DEPTH; i++) slot[i] = '0;
      held = 0;
      restart_pattern();
    endfunction

    function void restart_pattern();
      cycles_done = '0;
      phase       = PH_START;
      beeps_done  = '0;
      time_left   = '0;
    endfunction

    function int find_tag(logic [7:0] tag);
      for (int unsigned i = 0; i < held; i++)
        if (slot[i].tag == tag) return int'(i);
      return -1;
    endfunction

    function void remove_at(int unsigned idx);
      for (int unsigned i = idx; i + 1 < held; i++) slot[i] = slot[i + 1];
      if (held > 0) held--;
      if (idx == 0) restart_pattern();
    endfunction

    // Stable insertion by urgency; a new head restarts the pattern
    function status_e insert_alarm(alarm_req_t r);
      entry_t      fresh;
      int unsigned pos;
      fresh.tag        = r.tag;
      fresh.on_time    = r.on_time;
      fresh.gap_time   = r.gap_time;
      fresh.beeps      = r.beeps;
      fresh.pause_time = r.pause_time;
      fresh.limit      = r.limit;
      fresh.urg        = r.urg;
      if (find_tag(r.tag) >= 0) return STS_DUP;
      if (held >= QUEUE_DEPTH) return STS_FULL;
      pos = held;
      while (pos > 0 && slot[pos - 1].urg > fresh.urg) begin
        slot[pos] = slot[pos - 1];
        pos--;
      end
      slot[pos] = fresh;
      held++;
      if (pos == 0) restart_pattern();
      return STS_DONE;
    endfunction

    // One millisecond of the head pattern; zero-length phases fall through
    function logic play_tick();
      logic   completed;
      entry_t head;
      completed = 1'b0;
      for (int guard = 0; guard < 16; guard++) begin
        if (held == 0) return 1'b0;
        head = slot[0];
        if (phase != PH_START && time_left != 0) begin
          time_left--;
          return phase == PH_ON;
        end
        case (phase)
          PH_START: begin
            beeps_done = '0;
            if (head.beeps != 0) begin
              phase     = PH_ON;
              time_left = head.on_time;
            end else begin
              phase     = PH_PAUSE;
              time_left = head.pause_time;
            end
          end
          PH_ON: begin
            // both times zero: rest of the beeps go at once
            if (head.on_time == 0 && head.gap_time == 0) beeps_done = head.beeps;
            else if (beeps_done < head.beeps) beeps_done++;
            if (beeps_done < head.beeps) begin
              phase     = PH_GAP;
              time_left = head.gap_time;
            end else begin
              phase     = PH_PAUSE;
              time_left = head.pause_time;
            end
          end
          PH_GAP: begin
            phase     = PH_ON;
            time_left = head.on_time;
          end
          default: begin
            // only one cycle may finish per tick
            if (completed) begin
              phase = PH_START;
              return 1'b0;
            end
            completed = 1'b1;
            if (cycles_done != 16'hFFFF) cycles_done++;
            if (head.limit != 0 && cycles_done >= head.limit) begin
              remove_at(0);
            end else begin
              phase      = PH_START;
              beeps_done = '0;
              time_left  = '0;
            end
          end
        endcase
      end
      return 1'b0;
    endfunction

    // Accepted request: advance the shadow state, queue the result it causes
    function void note_transfer(alarm_req_t r);
      alarm_rsp_t rsp;
      int         idx;
      rsp        = '0;
      rsp.status = STS_DONE;
      case (r.func)
        FN_TICK: begin
          rsp.level = play_tick();
          n_tick++;
          if (rsp.level) n_sound++;
        end
        FN_TRIG: begin
          rsp.status = insert_alarm(r);
          n_trig++;
          if (rsp.status == STS_DUP) n_dup++;
          if (rsp.status == STS_FULL) n_full++;
        end
        FN_CLEAR: begin
          idx = find_tag(r.tag);
          n_clear++;
          if (idx < 0) begin
            rsp.status = STS_MISS;
            n_miss++;
          end else begin
            remove_at(idx);
          end
        end
        default: begin
          held = 0;
          restart_pattern();
          n_stop++;
        end
      endcase
      rsp.busy    = held != 0;
      rsp.present = find_tag(r.tag) >= 0;
      rsp.held    = 4'(held);
      alarm_rsp_q.push_back(rsp);
    endfunction

    function void report(string what, alarm_rsp_t want, alarm_rsp_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t %s: expected lvl=%0b busy=%0b tag=%0b sts=%0d held=%0d, got lvl=%0b busy=%0b tag=%0b sts=%0d held=%0d",
                 $time, what, want.level, want.busy, want.present, want.status, want.held,
                 got.level, got.busy, got.present, got.status, got.held);
    endfunction

    function void check_result(alarm_rsp_t got);
      alarm_rsp_t want;
      if (alarm_rsp_q.size() == 0) begin
        report("result with nothing pending", '0, got);
        return;
      end
      want = alarm_rsp_q.pop_front();
      checked++;
      if (got.level !== want.level || got.busy !== want.busy ||
          got.present !== want.present || got.status !== want.status ||
          got.held !== want.held)
        report("result mismatch", want, got);
    endfunction
  endclass

  // DUT signals; every input starts at a known value
  logic        clk_i              = 1'b0;
  logic        rst_ni             = 1'b0;
  logic        in_valid_i         = 1'b0;
  logic        in_ready_o;
  logic [1:0]  func_i             = '0;
  logic [7:0]  alarm_tag_i        = '0;
  logic [15:0] beep_on_time_i     = '0;
  logic [15:0] beep_gap_time_i    = '0;
  logic [7:0]  beeps_per_cycle_i  = '0;
  logic [15:0] cycle_pause_time_i = '0;
  logic [15:0] cycle_limit_i      = '0;
  logic [7:0]  urgency_i          = '0;
  logic        out_valid_o;
  logic        out_ready_i        = 1'b0;
  logic        buzzer_level_o;
  logic        queue_busy_o;
  logic        tag_present_o;
  logic [1:0]  command_status_o;
  logic [3:0]  entries_held_o;

  alarm_scoreboard sb;
  alarm_rsp_t      seen_rsp;
  int unsigned     cycle_count = 0;
  int unsigned     burst_left  = 0;

  priority_alarm_beep_sequencer_core u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .func_i             (func_i),
    .alarm_tag_i        (alarm_tag_i),
    .beep_on_time_i     (beep_on_time_i),
    .beep_gap_time_i    (beep_gap_time_i),
    .beeps_per_cycle_i  (beeps_per_cycle_i),
    .cycle_pause_time_i (cycle_pause_time_i),
    .cycle_limit_i      (cycle_limit_i),
    .urgency_i          (urgency_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .buzzer_level_o     (buzzer_level_o),
    .queue_busy_o       (queue_busy_o),
    .tag_present_o      (tag_present_o),
    .command_status_o   (command_status_o),
    .entries_held_o     (entries_held_o)
  );

  always #4 clk_i = ~clk_i;

  // Run time guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Output side: check every result transfer
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_rsp.level   = buzzer_level_o;
      seen_rsp.busy    = queue_busy_o;
      seen_rsp.present = tag_present_o;
      seen_rsp.status  = status_e'(command_status_o);
      seen_rsp.held    = entries_held_o;
      sb.check_result(seen_rsp);
    end
  end

  // Output side: random back-pressure, mostly short stalls, some long, some none
  initial begin : ready_gen
    int unsigned run, pick;
    logic        lvl;
    wait (rst_ni);
    forever begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        lvl = 1'b1;
        run = $urandom_range(20, 80);
      end else if (pick < 70) begin
        lvl = 1'b0;
        run = $urandom_range(1, 3);
      end else if (pick < 90) begin
        lvl = 1'b1;
        run = $urandom_range(1, 4);
      end else begin
        lvl = 1'b0;
        run = $urandom_range(15, 60);
      end
      repeat (run) begin
        @(posedge clk_i);
        out_ready_i <= lvl;
      end
    end
  end

  // Idle cycles ahead of the next request; occasional bursts with none
  function automatic int unsigned pick_gap();
    int unsigned pick;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      burst_left = $urandom_range(10, 30);
      return 0;
    end
    if (pick < 45) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_time();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 16'($urandom_range(0, 3));
    if (pick < 95) return 16'($urandom_range(4, 20));
    return 16'($urandom);
  endfunction

  function automatic alarm_req_t mk_req(func_e fn, logic [7:0] tag, logic [15:0] on_t,
                                        logic [15:0] gap_t, logic [7:0] beeps,
                                        logic [15:0] pause_t, logic [15:0] limit,
                                        logic [7:0] urg);
    alarm_req_t r;
    r.func       = fn;
    r.tag        = tag;
    r.on_time    = on_t;
    r.gap_time   = gap_t;
    r.beeps      = beeps;
    r.pause_time = pause_t;
    r.limit      = limit;
    r.urg        = urg;
    return r;
  endfunction

  // Random request shaped by the current queue contents
  function automatic alarm_req_t random_req();
    alarm_req_t  r;
    int unsigned pick;
    r = alarm_req_t'({$urandom, $urandom, $urandom, $urandom});
    r.tag = ($urandom_range(0, 99) < 75) ? 8'($urandom_range(0, 11)) : 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 62) begin
      r.func = FN_TICK;
    end else if (pick < 87) begin
      r.func       = FN_TRIG;
      r.on_time    = pick_time();
      r.gap_time   = pick_time();
      r.pause_time = pick_time();
      pick = $urandom_range(0, 99);
      r.beeps = (pick < 70) ? 8'($urandom_range(0, 3)) :
                (pick < 95) ? 8'($urandom_range(4, 8)) : 8'hFF;
      pick = $urandom_range(0, 99);
      r.limit = (pick < 60) ? 16'($urandom_range(1, 3)) :
                (pick < 85) ? 16'h0000 : 16'($urandom);
      r.urg = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      if (sb.held != 0 && $urandom_range(0, 99) < 15)
        r.tag = sb.slot[$urandom_range(0, sb.held - 1)].tag;
    end else if (pick < 97) begin
      r.func = FN_CLEAR;
      if (sb.held != 0 && $urandom_range(0, 99) < 60)
        r.tag = sb.slot[$urandom_range(0, sb.held - 1)].tag;
    end else begin
      r.func = FN_STOP;
    end
    return r;
  endfunction

  // Input side: optional idle gap, then hold the request until its transfer
  task automatic send_req(alarm_req_t r);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    func_i             <= r.func;
    alarm_tag_i        <= r.tag;
    beep_on_time_i     <= r.on_time;
    beep_gap_time_i    <= r.gap_time;
    beeps_per_cycle_i  <= r.beeps;
    cycle_pause_time_i <= r.pause_time;
    cycle_limit_i      <= r.limit;
    urgency_i          <= r.urg;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_transfer(r);
  endtask

  initial begin : stimulus
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty queue, zero-length cycle, extremes, duplicate, full queue
    send_req(mk_req(FN_TICK,  8'd0,   '0, '0, '0, '0, '0, '0));
    send_req(mk_req(FN_CLEAR, 8'd0,   '0, '0, '0, '0, '0, '0));
    send_req(mk_req(FN_STOP,  8'd0,   '0, '0, '0, '0, '0, '0));
    send_req(mk_req(FN_TRIG,  8'd0,   '0, '0, '0, '0, '0, 8'hFF));
    send_req(mk_req(FN_TICK,  8'd0,   '0, '0, '0, '0, '0, '0));
    send_req(mk_req(FN_TICK,  8'd0,   '0, '0, '0, '0, '0, '0));
    send_req(mk_req(FN_TRIG,  8'd0,   16'd5, 16'd5, 8'd1, 16'd5, 16'd1, 8'd3));
    send_req(mk_req(FN_TRIG,  8'hFF,  16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'd0));
    send_req(mk_req(FN_TICK,  8'hFF,  '0, '0, '0, '0, '0, '0));
    send_req(mk_req(FN_TRIG,  8'd1,   16'd1, 16'd1, 8'd2, 16'd1, 16'd2, 8'd5));
    send_req(mk_req(FN_TRIG,  8'd2,   16'd2, 16'd0, 8'd3, 16'd0, 16'd1, 8'd5));
    send_req(mk_req(FN_TRIG,  8'd3,   16'd0, 16'd3, 8'd1, 16'd2, 16'd0, 8'hFF));
    send_req(mk_req(FN_TRIG,  8'd4,   16'd1, 16'd0, 8'd0, 16'd1, 16'd3, 8'd0));
    send_req(mk_req(FN_TRIG,  8'd5,   16'd3, 16'd2, 8'd4, 16'd0, 16'd2, 8'd128));
    send_req(mk_req(FN_TRIG,  8'd6,   16'd1, 16'd1, 8'd1, 16'd1, 16'd1, 8'd7));
    send_req(mk_req(FN_TRIG,  8'd7,   16'd1, 16'd1, 8'd1, 16'd1, 16'd1, 8'd1));
    send_req(mk_req(FN_CLEAR, 8'd3,   '0, '0, '0, '0, '0, '0));
    send_req(mk_req(FN_CLEAR, 8'hFF,  '0, '0, '0, '0, '0, '0));
    send_req(mk_req(FN_TICK,  8'd4,   '0, '0, '0, '0, '0, '0));
    send_req(mk_req(FN_STOP,  8'd4,   '0, '0, '0, '0, '0, '0));
    // on and gap both zero, then head dropped by its limit mid-tick
    send_req(mk_req(FN_TRIG,  8'd9,   16'd0, 16'd0, 8'd3, 16'd1, 16'd1, 8'd0));
    send_req(mk_req(FN_TRIG,  8'd10,  16'd1, 16'd0, 8'd2, 16'd0, 16'd2, 8'd9));
    repeat (4) send_req(mk_req(FN_TICK, 8'd10, '0, '0, '0, '0, '0, '0));
    send_req(mk_req(FN_CLEAR, 8'd200, '0, '0, '0, '0, '0, '0));

    // Random traffic
    repeat (RANDOM_ITEMS) send_req(random_req());
    in_valid_i <= 1'b0;

    // Drain
    while (sb.alarm_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d ticks (%0d sounding), %0d triggers, %0d clears, %0d stop-alls",
             sb.n_tick, sb.n_sound, sb.n_trig, sb.n_clear, sb.n_stop);
    $display("Rejected: %0d duplicates, %0d queue full, %0d unknown tags; %0d results checked",
             sb.n_dup, sb.n_full, sb.n_miss, sb.checked);
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/pabs_pkg.sv
hw/rtl/pabs_cell.sv
hw/rtl/pabs_player.sv
hw/rtl/priority_alarm_beep_sequencer_core.sv
hw/rtl/pabs_checker.sv
test/priority_alarm_beep_sequencer_core_tb.sv
